>>> src/pmpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_pkg: shared types and constants for the mouse packet cursor
// Holds the header bit positions, the configuration register codes and the
// structures passed between the framer, the cursor unit and the top level.
// ----------------------------------------------------------------------------
package pmpc_pkg;

   // Width of the screen dimension registers and of the configuration port.
   localparam int DIM_W      = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   // Reset values of the screen dimensions.
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd768;

   // Header byte bit positions.
   localparam int HDR_LEFT   = 0;
   localparam int HDR_RIGHT  = 1;
   localparam int HDR_MIDDLE = 2;
   localparam int HDR_SYNC   = 3;
   localparam int HDR_X_SIGN = 4;
   localparam int HDR_Y_SIGN = 5;
   localparam int HDR_X_OVF  = 6;
   localparam int HDR_Y_OVF  = 7;

   // Extra movement applied when a delta overflow bit is set.
   localparam int OVF_EXTRA = 255;

   // Byte position within a packet.
   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_X      = 3'b010,
      PH_Y      = 3'b100
   } phase_type;

   // One complete packet as framed from three beats.
   typedef struct packed {
      logic [7:0] header;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
   } packet_type;

   // Screen dimensions from the configuration registers.
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } dims_type;

endpackage

>>> src/pmpc_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_framer: byte framer for three-byte mouse packets
// Drops the first beat after reset, synchronizes on header bit 3 and hands a
// complete packet to the cursor unit through a one-entry packet register.
// ----------------------------------------------------------------------------
module pmpc_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   output logic                  pkt_valid,
   input  logic                  pkt_ready,
   output pmpc_pkg::packet_type  pkt
);
   import pmpc_pkg::*;

   logic       skip_ff, skip_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] xbyte_ff, xbyte_in;
   logic       pkt_valid_ff, pkt_valid_in;
   packet_type pkt_ff, pkt_in;
   logic       accept;
   logic       complete;

   // The packet register frees up in the same cycle the cursor unit takes it.
   assign req_ready = !pkt_valid_ff || pkt_ready;
   assign accept    = req_valid && req_ready;

   // Framing state for each accepted beat.
   always_comb begin
      skip_in   = skip_ff;
      phase_in  = phase_ff;
      header_in = header_ff;
      xbyte_in  = xbyte_ff;
      complete  = 1'b0;
      if (accept) begin
         if (skip_ff) begin
            skip_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_X: begin
                  xbyte_in = req_data_byte;
                  phase_in = PH_Y;
               end
               PH_Y: begin
                  phase_in = PH_HEADER;
                  complete = 1'b1;
               end
               default: begin
                  // Header phase; a byte without the sync bit is dropped.
                  if (req_data_byte[HDR_SYNC]) begin
                     header_in = req_data_byte;
                     phase_in  = PH_X;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
            endcase
         end
      end
   end

   // Packet register load and release.
   always_comb begin
      pkt_in        = pkt_ff;
      pkt_valid_in  = pkt_valid_ff && !pkt_ready;
      if (complete) begin
         pkt_in.header = header_ff;
         pkt_in.x_byte = xbyte_ff;
         pkt_in.y_byte = req_data_byte;
         pkt_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff      <= 1'b1;
         phase_ff     <= PH_HEADER;
         header_ff    <= '0;
         xbyte_ff     <= '0;
         pkt_valid_ff <= 1'b0;
      end else begin
         skip_ff      <= skip_in;
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         xbyte_ff     <= xbyte_in;
         pkt_valid_ff <= pkt_valid_in;
      end
   end

   // Packet payload needs no reset.
   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign pkt_valid = pkt_valid_ff;
   assign pkt       = pkt_ff;

endmodule

>>> src/pmpc_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_cursor: cursor position update and result register
// Applies one packet's signed deltas to the cursor, clamps each coordinate to
// the screen and holds the result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module pmpc_cursor #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pkt_valid,
   output logic                   pkt_ready,
   input  pmpc_pkg::packet_type   pkt,
   input  pmpc_pkg::dims_type     dims,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_BITS-1:0]  rsp_pos_x,
   output logic [COORD_BITS-1:0]  rsp_pos_y,
   output logic                   rsp_left_button,
   output logic                   rsp_right_button,
   output logic                   rsp_middle_button
);
   import pmpc_pkg::*;

   // Signed working width: holds the coordinate, the delta and the dimension.
   localparam int SUM_W = ((COORD_BITS + 2) > (DIM_W + 1)) ? (COORD_BITS + 2) : (DIM_W + 1);
   localparam logic [SUM_W-1:0] COORD_MAX = SUM_W'((64'd1 << COORD_BITS) - 64'd1);

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]  cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]  cursor_y_ff, cursor_y_in;
   logic [2:0]             buttons_ff, buttons_in;
   logic                   take;
   logic signed [SUM_W-1:0] dx, dy, sum_x, sum_y;

   // Nine-bit signed delta with the overflow extra in the direction of its sign.
   function automatic logic signed [SUM_W-1:0] delta(input logic [7:0] raw,
                                                      input logic neg,
                                                      input logic ovf);
      logic signed [SUM_W-1:0] d;
      d = SUM_W'(signed'({neg, raw}));
      if (ovf) begin
         if (neg) begin
            d = d - SUM_W'(OVF_EXTRA);
         end else begin
            d = d + SUM_W'(OVF_EXTRA);
         end
      end
      return d;
   endfunction

   // Saturate to 0..dim-1 and to COORD_MAX; a zero dimension counts as one.
   function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                         input logic [DIM_W-1:0] dim);
      logic [SUM_W-1:0] hi;
      logic [COORD_BITS-1:0] r;
      hi = (dim == '0) ? '0 : SUM_W'(dim - DIM_W'(1));
      if (hi > COORD_MAX) begin
         hi = COORD_MAX;
      end
      if (v < 0) begin
         r = '0;
      end else if ($unsigned(v) > hi) begin
         r = hi[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // A packet is taken when the result register is empty or being drained.
   assign pkt_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pkt_valid && pkt_ready;

   // Position arithmetic; y moves opposite to its delta.
   assign dx    = delta(pkt.x_byte, pkt.header[HDR_X_SIGN], pkt.header[HDR_X_OVF]);
   assign dy    = delta(pkt.y_byte, pkt.header[HDR_Y_SIGN], pkt.header[HDR_Y_OVF]);
   assign sum_x = SUM_W'(signed'({1'b0, cursor_x_ff})) + dx;
   assign sum_y = SUM_W'(signed'({1'b0, cursor_y_ff})) - dy;

   // Next cursor, buttons and result valid.
   always_comb begin
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      buttons_in   = buttons_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         cursor_x_in  = clamp_coord(sum_x, dims.width);
         cursor_y_in  = clamp_coord(sum_y, dims.height);
         buttons_in   = {pkt.header[HDR_MIDDLE], pkt.header[HDR_RIGHT], pkt.header[HDR_LEFT]};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
      end
   end

   // Button payload needs no reset.
   always_ff @(posedge clock) begin
      buttons_ff <= buttons_in;
   end

   // The cursor registers double as the result position.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = cursor_x_ff;
   assign rsp_pos_y         = cursor_y_ff;
   assign rsp_left_button   = buttons_ff[0];
   assign rsp_right_button  = buttons_ff[1];
   assign rsp_middle_button = buttons_ff[2];

endmodule

>>> src/ps2_mouse_packet_cursor_top.sv
`timescale 1ns / 1ps
// Path: the third byte of a packet is loaded into the packet register, then
// the cursor result register. Throughput: one byte per cycle while req_ready
// is high; the cursor add and clamp are combinational.
// Reset: synchronous; drops the next byte, restarts framing, cursor at 0,0,
// screen 1024 by 768. No memories, so no clearing pass.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_top: PS/2 mouse packet decoder with cursor
// Frames mouse bytes into packets, keeps a clamped cursor position and
// emits position and buttons for every completed packet.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [COORD_BITS-1:0]             rsp_pos_x,
   output logic [COORD_BITS-1:0]             rsp_pos_y,
   output logic                              rsp_left_button,
   output logic                              rsp_right_button,
   output logic                              rsp_middle_button,
   input  logic                              csr_we,
   input  logic [pmpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pmpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pmpc_pkg::*;

   dims_type   dims_ff, dims_in;
   logic       pkt_valid;
   logic       pkt_ready;
   packet_type pkt;

   // Configuration registers; writes to unknown indexes are ignored.
   always_comb begin
      dims_in = dims_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  dims_in.width  = DIM_W'(csr_wdata);
            CSR_SCREEN_HEIGHT: dims_in.height = DIM_W'(csr_wdata);
            default:           dims_in        = dims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.width  <= WIDTH_RESET;
         dims_ff.height <= HEIGHT_RESET;
      end else begin
         dims_ff <= dims_in;
      end
   end

   // Byte framing.
   pmpc_framer u_framer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .pkt_valid     (pkt_valid),
      .pkt_ready     (pkt_ready),
      .pkt           (pkt)
   );

   // Cursor update and result beat.
   pmpc_cursor #(
      .COORD_BITS (COORD_BITS)
   ) u_cursor (
      .clock             (clock),
      .reset             (reset),
      .pkt_valid         (pkt_valid),
      .pkt_ready         (pkt_ready),
      .pkt               (pkt),
      .dims              (dims_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_left_button   (rsp_left_button),
      .rsp_right_button  (rsp_right_button),
      .rsp_middle_button (rsp_middle_button)
   );

   // The input stalls only when both the packet and result stages are full.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && pkt_valid))
      else $error("input stalled while a stage had room");

   // A packet waiting on a full result register stays in place.
   a_pkt_hold: assert property (@(posedge clock) disable iff (reset)
      (pkt_valid && !pkt_ready) |=> (pkt_valid && $stable(pkt)))
      else $error("pending packet lost or changed");

   // A new result only follows a packet handed to the cursor unit.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pkt_valid && pkt_ready))
      else $error("result appeared without a packet");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the PS/2 mouse packet cursor
// Streams mouse bytes into the decoder over a valid/ready channel and tracks
// the framing and the clamped cursor in a local model. Every report beat is
// compared with the oldest predicted report. A short directed table comes
// first. Random phases follow, each with its own screen size and its own
// idle and stall pattern on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import pmpc_pkg::*;

   localparam int COORD_BITS    = 12;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int DELTA_SPAN    = 256;
   localparam int NUM_PHASES    = 8;
   localparam int BYTES_PER_PH  = 220;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS   = 10;

   // Register indexes past the end of the list; writes to them are dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  left;
      logic                  right;
      logic                  middle;
   } cursor_report_type;

   typedef struct packed {
      logic [7:0]        data;
      logic              typed;
      cursor_report_type rep;
   } stim_row_type;

   logic                    clock;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_data_byte  = 8'h00;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic [COORD_BITS-1:0]   rsp_pos_x;
   logic [COORD_BITS-1:0]   rsp_pos_y;
   logic                    rsp_left_button;
   logic                    rsp_right_button;
   logic                    rsp_middle_button;
   logic                    csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index      = CSR_SCREEN_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_wdata      = '0;

   // Model of the decoder state and the screen registers.
   logic                    drop_next      = 1'b1;
   phase_type               frame_phase    = PH_HEADER;
   logic [7:0]              held_header    = 8'h00;
   logic [7:0]              held_x_byte    = 8'h00;
   int                      cursor_x       = 0;
   int                      cursor_y       = 0;
   int unsigned             screen_w       = WIDTH_RESET;
   int unsigned             screen_h       = HEIGHT_RESET;

   cursor_report_type       pending_reports[$];
   stim_row_type            directed_rows[$];
   int                      framed_bytes   = 0;
   int                      fault_count    = 0;
   int                      sender_idle_pct    = 0;
   int                      receiver_stall_pct = 0;

   // Screen size and channel pattern for each random phase.
   int unsigned phase_width  [NUM_PHASES] = '{1024, 1, 0, 4096, 8191, 640, 200, 0};
   int unsigned phase_height [NUM_PHASES] = '{768, 1, 0, 4096, 5000, 480, 4095, 0};
   int          phase_idle   [NUM_PHASES] = '{0, 69, 0, 27, 0, 69, 0, 27};
   int          phase_stall  [NUM_PHASES] = '{0, 0, 69, 27, 0, 0, 69, 27};

   ps2_mouse_packet_cursor_top #(
      .COORD_BITS(COORD_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_left_button  (rsp_left_button),
      .rsp_right_button (rsp_right_button),
      .rsp_middle_button(rsp_middle_button),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A 9-bit two's complement delta, widened by the overflow extra.
   function automatic int movement(logic [7:0] raw, logic neg, logic ovf);
      int d;
      d = int'(raw);
      if (neg) begin
         d = d - DELTA_SPAN;
         if (ovf) d = d - OVF_EXTRA;
      end else if (ovf) begin
         d = d + OVF_EXTRA;
      end
      return d;
   endfunction

   // Saturate to the screen; a zero dimension acts as one pixel.
   function automatic int clamp_to_screen(int v, int unsigned dim);
      int hi;
      hi = (dim == 0) ? 0 : int'(dim) - 1;
      if (hi > COORD_MAX) hi = COORD_MAX;
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      return v;
   endfunction

   // Advance the model by one accepted byte; made is set when a packet closes.
   task automatic decode_mouse_byte(input logic [7:0] b, output logic made,
                                    output cursor_report_type rep);
      made = 1'b0;
      rep  = '0;
      if (drop_next) begin
         drop_next = 1'b0;
      end else begin
         case (frame_phase)
            PH_X: begin
               held_x_byte  = b;
               frame_phase  = PH_Y;
               framed_bytes = framed_bytes + 1;
            end
            PH_Y: begin
               frame_phase  = PH_HEADER;
               framed_bytes = framed_bytes + 1;
               cursor_x = clamp_to_screen(cursor_x + movement(held_x_byte,
                             held_header[HDR_X_SIGN], held_header[HDR_X_OVF]), screen_w);
               cursor_y = clamp_to_screen(cursor_y - movement(b,
                             held_header[HDR_Y_SIGN], held_header[HDR_Y_OVF]), screen_h);
               rep.x      = COORD_BITS'(cursor_x);
               rep.y      = COORD_BITS'(cursor_y);
               rep.left   = held_header[HDR_LEFT];
               rep.right  = held_header[HDR_RIGHT];
               rep.middle = held_header[HDR_MIDDLE];
               made       = 1'b1;
            end
            default: begin
               // A header without the sync bit is skipped in place.
               if (b[HDR_SYNC]) begin
                  held_header  = b;
                  frame_phase  = PH_X;
                  framed_bytes = framed_bytes + 1;
               end else begin
                  frame_phase = PH_HEADER;
               end
            end
         endcase
      end
   endtask

   // Offer one beat after a random gap and hold it until it is taken.
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input cursor_report_type typed_rep);
      int gap = 0;
      logic made;
      cursor_report_type rep;
      if (sender_idle_pct > 0)
         while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_mouse_byte(b, made, rep);
      if (made) pending_reports.push_back(typed ? typed_rep : rep);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      if (idx == CSR_SCREEN_WIDTH) screen_w = value & 32'h1FFF;
      else if (idx == CSR_SCREEN_HEIGHT) screen_h = value & 32'h1FFF;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Stop offering beats, wait for every report, then let the pipe settle.
   task automatic drain_block();
      int waited = 0;
      req_valid <= 1'b0;
      while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic stim_row_type raw_row(logic [7:0] d);
      stim_row_type r;
      r      = '0;
      r.data = d;
      return r;
   endfunction

   function automatic stim_row_type typed_row(logic [7:0] d, int x, int y,
                                              logic l, logic r, logic m);
      stim_row_type s;
      s.data       = d;
      s.typed      = 1'b1;
      s.rep.x      = COORD_BITS'(x);
      s.rep.y      = COORD_BITS'(y);
      s.rep.left   = l;
      s.rep.right  = r;
      s.rep.middle = m;
      return s;
   endfunction

   // Report beats: compare with the oldest prediction, then pick the next stall.
   always @(posedge clock) begin : report_check
      cursor_report_type got;
      cursor_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_pos_x, rsp_pos_y, rsp_left_button, rsp_right_button,
                rsp_middle_button};
         if (pending_reports.size() == 0) begin
            fault_count = fault_count + 1;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: unexpected report x=%0d y=%0d l=%0b r=%0b m=%0b", $realtime,
                        got.x, got.y, got.left, got.right, got.middle);
         end else begin
            want = pending_reports.pop_front();
            if (got !== want) begin
               fault_count = fault_count + 1;
               if (fault_count <= MAX_REPORTS)
                  $display("%0t: mismatch exp x=%0d y=%0d lrm=%0b%0b%0b got x=%0d y=%0d lrm=%0b%0b%0b",
                           $realtime, want.x, want.y, want.left, want.right, want.middle,
                           got.x, got.y, got.left, got.right, got.middle);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   initial begin : stimulus
      logic [7:0] hdr;
      int         pick;
      int         goal;
      // The first byte after reset is dropped; sync-less headers are skipped.
      directed_rows.push_back(raw_row(8'h00));
      directed_rows.push_back(raw_row(8'h00));
      directed_rows.push_back(raw_row(8'h07));
      // Zero motion, no buttons.
      directed_rows.push_back(raw_row(8'h08));
      directed_rows.push_back(raw_row(8'h00));
      directed_rows.push_back(typed_row(8'h00, 0, 0, 1'b0, 1'b0, 1'b0));
      // All buttons; upward motion clamps at the top edge.
      directed_rows.push_back(raw_row(8'h0F));
      directed_rows.push_back(raw_row(8'h05));
      directed_rows.push_back(typed_row(8'h03, 5, 0, 1'b1, 1'b1, 1'b1));
      // Largest right step with overflow, twice, clamps at the right edge.
      directed_rows.push_back(raw_row(8'h48));
      directed_rows.push_back(raw_row(8'hFF));
      directed_rows.push_back(raw_row(8'h00));
      directed_rows.push_back(raw_row(8'h48));
      directed_rows.push_back(raw_row(8'hFF));
      directed_rows.push_back(typed_row(8'h00, 1023, 0, 1'b0, 1'b0, 1'b0));
      // Negative Y delta with a zero byte means minus 256.
      directed_rows.push_back(raw_row(8'h28));
      directed_rows.push_back(raw_row(8'h00));
      directed_rows.push_back(raw_row(8'h00));
      // Most negative X step with overflow.
      directed_rows.push_back(raw_row(8'h58));
      directed_rows.push_back(raw_row(8'h00));
      directed_rows.push_back(raw_row(8'h00));
      // Positive Y overflow drives the cursor past the top edge.
      directed_rows.push_back(raw_row(8'h88));
      directed_rows.push_back(raw_row(8'hFF));
      directed_rows.push_back(typed_row(8'hFF, 767, 0, 1'b0, 1'b0, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].rep);
      drain_block();

      goal = framed_bytes;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == NUM_PHASES - 1) begin
            write_reg(CSR_SCREEN_WIDTH, $urandom_range(8191));
            write_reg(CSR_SCREEN_HEIGHT, $urandom_range(8191));
         end else begin
            write_reg(CSR_SCREEN_WIDTH, phase_width[ph]);
            write_reg(CSR_SCREEN_HEIGHT, phase_height[ph]);
         end
         // Spare indexes must leave both dimensions untouched.
         if (ph >= 5) begin
            write_reg(CSR_SPARE_2, $urandom_range(8191));
            write_reg(CSR_SPARE_3, $urandom_range(8191));
         end
         sender_idle_pct    = phase_idle[ph];
         receiver_stall_pct = phase_stall[ph];
         goal = goal + BYTES_PER_PH;

         while (framed_bytes < goal) begin
            pick = $urandom_range(99);
            hdr  = 8'($urandom);
            if (pick < 80) begin
               // Well-formed packet; overflow bits are rarer so the cursor roams.
               hdr[HDR_SYNC] = 1'b1;
               if ($urandom_range(99) < 70) begin
                  hdr[HDR_X_OVF] = 1'b0;
                  hdr[HDR_Y_OVF] = 1'b0;
               end
               send_byte(hdr, 1'b0, '0);
               send_byte(8'($urandom), 1'b0, '0);
               send_byte(8'($urandom), 1'b0, '0);
            end else if (pick < 88) begin
               send_byte(8'($urandom), 1'b0, '0);
            end else if (pick < 94) begin
               hdr[HDR_SYNC] = 1'b0;
               send_byte(hdr, 1'b0, '0);
            end else begin
               // Truncated packet that throws the framing off.
               hdr[HDR_SYNC] = 1'b1;
               send_byte(hdr, 1'b0, '0);
               send_byte(8'($urandom), 1'b0, '0);
            end
         end
         drain_block();
      end

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      fault_count = fault_count + pending_reports.size();
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
src/pmpc_pkg.sv
src/pmpc_framer.sv
src/pmpc_cursor.sv
src/ps2_mouse_packet_cursor_top.sv
bench/tb_top.sv
